### sv/dual_blink_period_controller_core_defines.svh
// Assertion macros shared by the dual blink period controller RTL.
`ifndef DUAL_BLINK_PERIOD_CONTROLLER_CORE_DEFINES_SVH
`define DUAL_BLINK_PERIOD_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define DBPC_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define DBPC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/dbpc_pkg.sv
// Types, constants and helper functions of the dual blink period controller.
`timescale 1ns / 1ps
`default_nettype none

package dbpc_pkg;

   localparam int TICKS_PER_TENTH = 100;
   localparam int PERIOD_MAX_INT  = 50;
   localparam int ELAPSED_W       = $clog2(PERIOD_MAX_INT * TICKS_PER_TENTH + 1);

   typedef logic [ELAPSED_W-1:0] elapsed_type;
   typedef logic [5:0]           period_type;

   localparam period_type PERIOD_MIN      = 6'd10;
   localparam period_type PERIOD_MAX      = 6'd50;
   localparam period_type PERIOD_STEP     = 6'd5;
   localparam period_type PERIOD_FIRST_RST  = 6'd20;
   localparam period_type PERIOD_SECOND_RST = 6'd10;

   localparam logic [6:0] DECIMAL_BASE = 7'd10;
   localparam logic [7:0] DOT_BIT      = 8'h80;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_ONE  = 8'h31;
   localparam logic [7:0] CH_TWO  = 8'h32;

   localparam logic [2:0] DIGIT_FIRST_TENS  = 3'd7;
   localparam logic [2:0] DIGIT_FIRST_ONES  = 3'd6;
   localparam logic [2:0] DIGIT_SECOND_TENS = 3'd1;
   localparam logic [2:0] DIGIT_SECOND_ONES = 3'd0;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_UP   = 2'd1,
      CMD_DOWN = 2'd2,
      CMD_BYTE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      RPL_NONE   = 2'd0,
      RPL_OK     = 2'd1,
      RPL_FORMAT = 2'd2,
      RPL_RANGE  = 2'd3
   } reply_type;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic       led_first;
      logic       led_second;
      logic [7:0] segments;
      logic [2:0] digit_select;
      reply_type  reply_status;
      logic       reply_led;
      logic [6:0] reply_period;
   } result_type;

   function automatic logic [7:0] seg_of(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0:    s = 8'h3F;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5B;
         4'd3:    s = 8'h4F;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6D;
         4'd6:    s = 8'h7D;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7F;
         4'd9:    s = 8'h6F;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   // Tens digit of a 6-bit period by a compare ladder.
   function automatic logic [3:0] tens_of(input period_type p);
      logic [3:0] t;
      t = 4'd0;
      for (int k = 1; k <= 6; k++) begin
         if (p >= period_type'(k * 10)) t = 4'(k);
      end
      return t;
   endfunction

   function automatic logic [3:0] ones_of(input period_type p);
      logic [6:0] rem;
      rem = 7'(p) - 7'(tens_of(p)) * DECIMAL_BASE;
      return rem[3:0];
   endfunction

   function automatic period_type step_up(input period_type p);
      logic [6:0] s;
      s = 7'(p) + 7'(PERIOD_STEP);
      if (p >= PERIOD_MAX) return p;
      if (s > 7'(PERIOD_MAX)) return PERIOD_MAX;
      return s[5:0];
   endfunction

   function automatic period_type step_down(input period_type p);
      if (p <= PERIOD_MIN) return p;
      if (p >= PERIOD_MIN + PERIOD_STEP) return p - PERIOD_STEP;
      return PERIOD_MIN;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

endpackage

`default_nettype wire

### sv/dbpc_in_stage.sv
// Input register of the dual blink period controller.
`timescale 1ns / 1ps
`default_nettype none

module dbpc_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire dbpc_pkg::item_type req_item,
   input  wire logic               take,
   output logic                    full,
   output dbpc_pkg::item_type      item
);

   logic               full_ff, full_in;
   dbpc_pkg::item_type item_ff;
   logic               accept;

   assign req_tready = !full_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      full_in = full_ff;
      if (accept) begin
         full_in = 1'b1;
      end else if (take) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign full = full_ff;
   assign item = item_ff;

endmodule

`default_nettype wire

### sv/dbpc_engine.sv
// Blink, scan, button and command state with the combinational result logic.
`timescale 1ns / 1ps
`default_nettype none

`include "dual_blink_period_controller_core_defines.svh"

module dbpc_engine (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire dbpc_pkg::item_type item,
   output dbpc_pkg::result_type    result
);

   dbpc_pkg::period_type  period_first_ff, period_first_in;
   dbpc_pkg::period_type  period_second_ff, period_second_in;
   dbpc_pkg::elapsed_type elapsed_first_ff, elapsed_first_in;
   dbpc_pkg::elapsed_type elapsed_second_ff, elapsed_second_in;
   logic                  level_first_ff, level_first_in;
   logic                  level_second_ff, level_second_in;
   logic [1:0]            scan_ff, scan_in;
   logic [1:0]            count_ff, count_in;
   logic [7:0]            byte0_ff, byte1_ff;

   dbpc_pkg::elapsed_type lim_first, lim_second;
   logic [dbpc_pkg::ELAPSED_W:0] inc_first, inc_second;
   logic [3:0]            d1, d2;
   logic [6:0]            val;
   logic                  fmt_ok, in_range;

   assign lim_first  = dbpc_pkg::elapsed_type'(period_first_ff) *
                       dbpc_pkg::elapsed_type'(dbpc_pkg::TICKS_PER_TENTH);
   assign lim_second = dbpc_pkg::elapsed_type'(period_second_ff) *
                       dbpc_pkg::elapsed_type'(dbpc_pkg::TICKS_PER_TENTH);
   assign inc_first  = {1'b0, elapsed_first_ff} + 1'b1;
   assign inc_second = {1'b0, elapsed_second_ff} + 1'b1;

   assign fmt_ok   = (byte0_ff == dbpc_pkg::CH_ONE || byte0_ff == dbpc_pkg::CH_TWO) &&
                     dbpc_pkg::is_digit(byte1_ff) && dbpc_pkg::is_digit(item.rx_byte);
   assign d1       = 4'(byte1_ff - dbpc_pkg::CH_ZERO);
   assign d2       = 4'(item.rx_byte - dbpc_pkg::CH_ZERO);
   assign val      = 7'(d1) * dbpc_pkg::DECIMAL_BASE + 7'(d2);
   assign in_range = (val >= 7'(dbpc_pkg::PERIOD_MIN)) && (val <= 7'(dbpc_pkg::PERIOD_MAX));

   always_comb begin
      period_first_in   = period_first_ff;
      period_second_in  = period_second_ff;
      elapsed_first_in  = elapsed_first_ff;
      elapsed_second_in = elapsed_second_ff;
      level_first_in    = level_first_ff;
      level_second_in   = level_second_ff;
      scan_in           = scan_ff;
      count_in          = count_ff;
      result            = '0;

      case (item.command)
         dbpc_pkg::CMD_TICK: begin
            case (scan_ff)
               2'd0: begin
                  result.digit_select = dbpc_pkg::DIGIT_FIRST_TENS;
                  result.segments = dbpc_pkg::seg_of(dbpc_pkg::tens_of(period_first_ff)) |
                                    dbpc_pkg::DOT_BIT;
               end
               2'd1: begin
                  result.digit_select = dbpc_pkg::DIGIT_FIRST_ONES;
                  result.segments = dbpc_pkg::seg_of(dbpc_pkg::ones_of(period_first_ff));
               end
               2'd2: begin
                  result.digit_select = dbpc_pkg::DIGIT_SECOND_TENS;
                  result.segments = dbpc_pkg::seg_of(dbpc_pkg::tens_of(period_second_ff)) |
                                    dbpc_pkg::DOT_BIT;
               end
               default: begin
                  result.digit_select = dbpc_pkg::DIGIT_SECOND_ONES;
                  result.segments = dbpc_pkg::seg_of(dbpc_pkg::ones_of(period_second_ff));
               end
            endcase
            scan_in = scan_ff + 2'd1;

            // restart a counter and toggle its LED once it reaches the period times TICKS_PER_TENTH
            if (inc_first >= {1'b0, lim_first}) begin
               elapsed_first_in = '0;
               level_first_in   = !level_first_ff;
            end else begin
               elapsed_first_in = inc_first[dbpc_pkg::ELAPSED_W-1:0];
            end
            if (inc_second >= {1'b0, lim_second}) begin
               elapsed_second_in = '0;
               level_second_in   = !level_second_ff;
            end else begin
               elapsed_second_in = inc_second[dbpc_pkg::ELAPSED_W-1:0];
            end
         end
         dbpc_pkg::CMD_UP: begin
            period_first_in   = dbpc_pkg::step_up(period_first_ff);
            period_second_in  = dbpc_pkg::step_up(period_second_ff);
            elapsed_first_in  = '0;
            elapsed_second_in = '0;
         end
         dbpc_pkg::CMD_DOWN: begin
            period_first_in   = dbpc_pkg::step_down(period_first_ff);
            period_second_in  = dbpc_pkg::step_down(period_second_ff);
            elapsed_first_in  = '0;
            elapsed_second_in = '0;
         end
         default: begin
            if (count_ff < 2'd2) begin
               count_in = count_ff + 2'd1;
            end else begin
               count_in = 2'd0;
               if (!fmt_ok) begin
                  result.reply_status = dbpc_pkg::RPL_FORMAT;
               end else begin
                  // '1' selects the first LED, '2' the second: bit 0 is inverted
                  result.reply_led    = !byte0_ff[0];
                  result.reply_period = val;
                  if (in_range) begin
                     result.reply_status = dbpc_pkg::RPL_OK;
                     if (byte0_ff[0]) begin
                        period_first_in = val[5:0];
                     end else begin
                        period_second_in = val[5:0];
                     end
                     elapsed_first_in  = '0;
                     elapsed_second_in = '0;
                  end else begin
                     result.reply_status = dbpc_pkg::RPL_RANGE;
                  end
               end
            end
         end
      endcase

      result.led_first  = level_first_in;
      result.led_second = level_second_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_first_ff   <= dbpc_pkg::PERIOD_FIRST_RST;
         period_second_ff  <= dbpc_pkg::PERIOD_SECOND_RST;
         elapsed_first_ff  <= '0;
         elapsed_second_ff <= '0;
         level_first_ff    <= 1'b0;
         level_second_ff   <= 1'b0;
         scan_ff           <= 2'd0;
         count_ff          <= 2'd0;
      end else if (fire) begin
         period_first_ff   <= period_first_in;
         period_second_ff  <= period_second_in;
         elapsed_first_ff  <= elapsed_first_in;
         elapsed_second_ff <= elapsed_second_in;
         level_first_ff    <= level_first_in;
         level_second_ff   <= level_second_in;
         scan_ff           <= scan_in;
         count_ff          <= count_in;
      end
   end

   // hold the first two command bytes until the third arrives
   always_ff @(posedge clock) begin
      if (fire && item.command == dbpc_pkg::CMD_BYTE) begin
         if (count_ff == 2'd0) byte0_ff <= item.rx_byte;
         if (count_ff == 2'd1) byte1_ff <= item.rx_byte;
      end
   end

   `DBPC_ASSERT_NOW(a_period_first_range, clock, reset, 1'b1,
      period_first_ff >= dbpc_pkg::PERIOD_MIN && period_first_ff <= dbpc_pkg::PERIOD_MAX,
      "first period left its legal range")
   `DBPC_ASSERT_NOW(a_period_second_range, clock, reset, 1'b1,
      period_second_ff >= dbpc_pkg::PERIOD_MIN && period_second_ff <= dbpc_pkg::PERIOD_MAX,
      "second period left its legal range")
   `DBPC_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff != 2'd3,
      "command byte count overran")
   `DBPC_ASSERT_NEXT(a_elapsed_below_limit, clock, reset, fire,
      elapsed_first_ff < lim_first && elapsed_second_ff < lim_second,
      "elapsed counter reached its limit without restarting")

endmodule

`default_nettype wire

### sv/dbpc_out_stage.sv
// Result register of the dual blink period controller.
`timescale 1ns / 1ps
`default_nettype none

`include "dual_blink_period_controller_core_defines.svh"

module dbpc_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire dbpc_pkg::result_type result,
   output logic                      space,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [23:0]               rsp_tdata
);

   logic                 valid_ff, valid_in;
   dbpc_pkg::result_type result_ff;

   assign space = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, result_ff.reply_period, result_ff.reply_led,
                        result_ff.reply_status, result_ff.digit_select,
                        result_ff.segments, result_ff.led_second, result_ff.led_first};

   `DBPC_ASSERT_NOW(a_no_overwrite, clock, reset, load, space,
      "result register loaded while a beat was still pending")
   `DBPC_ASSERT_NEXT(a_load_shows, clock, reset, load, rsp_tvalid,
      "loaded result not presented")

endmodule

`default_nettype wire

### sv/dual_blink_period_controller_core.sv
// Dual blink period controller: input register, engine, result register.
// An accepted beat passes the input register, engine and result register to rsp_.
// Throughput: one beat per cycle unless stalled; the state updates as each beat fires.
// A stalled result holds the input register full, and one more beat waits there.
// Reset (synchronous, active high): periods 20 and 10, counters, levels, scan and
// byte count cleared, both channels empty.
`timescale 1ns / 1ps
`default_nettype none

module dual_blink_period_controller_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [1:0]  req_tuser,   // [1:0] command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // [0] led_first, [1] led_second, [9:2] segments,
                                         // [12:10] digit_select, [14:13] reply_status,
                                         // [15] reply_led, [22:16] reply_period, [23] zero
);

   dbpc_pkg::item_type   req_item, item;
   dbpc_pkg::result_type result;
   logic                 full, space, fire;

   assign req_item.command = dbpc_pkg::cmd_type'(req_tuser);
   assign req_item.rx_byte = req_tdata;
   assign fire             = full && space;

   dbpc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (fire),
      .full       (full),
      .item       (item)
   );

   dbpc_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   dbpc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result     (result),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
